// ----- src/rml_pkg.sv -----
`timescale 1ns / 1ps

package rml_pkg;

    // Sizing of the ring table and of the angle and coordinate paths
    localparam int MAX_RINGS  = 8;
    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 18;

    // Field widths
    localparam int HIT_W  = COORD_BITS;
    localparam int SLOT_W = 3;
    localparam int RAD_W  = 18;
    localparam int CNT_W  = 8;
    localparam int NUM_W  = 11;
    localparam int RCNT_W = 4;
    localparam int HALF_W = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RING_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SIZE  = 2'd1;

    // Operation codes carried in s_tuser
    localparam logic OP_LOCATE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Stream packing, first field in the lowest bits
    localparam int X_LSB     = 0;
    localparam int Y_LSB     = X_LSB + HIT_W;
    localparam int SLOT_LSB  = Y_LSB + HIT_W;
    localparam int RAD_LSB   = SLOT_LSB + SLOT_W;
    localparam int CNT_LSB   = RAD_LSB + RAD_W;
    localparam int S_BITS    = CNT_LSB + CNT_W;
    localparam int S_TDATA_W = ((S_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUM_W + 7) / 8) * 8;

    // Datapath widths
    localparam int TURN_W = 32;
    localparam int XW     = COORD_BITS + 3;
    localparam int MW0    = (COORD_BITS > RAD_W + 1) ? COORD_BITS : RAD_W + 1;
    localparam int MW     = (MW0 > ANGLE_BITS) ? MW0 : ANGLE_BITS;
    localparam int PW     = 2 * MW;
    localparam int R2_W   = PW + 1;
    localparam int RING_W = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int LIM_W  = $clog2(MAX_RINGS + 1);
    localparam int LOOP_N = (ANGLE_BITS > MAX_RINGS) ? ANGLE_BITS : MAX_RINGS;
    localparam int IDX_W  = $clog2(LOOP_N);
    localparam int CMP_W  = ((IDX_W > LIM_W) ? IDX_W : LIM_W) + 1;

    localparam logic [TURN_W-1:0] HALF_TURN = 32'h8000_0000;
    localparam logic [TURN_W-1:0] ROUND_BIT = 32'd1 << (31 - ANGLE_BITS);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             load;
        logic             write;
        logic             sq_x;
        logic             sq_y;
        logic             step;
        logic             round;
        logic             fetch;
        logic             mul_hi;
        logic             mul_lo;
        logic             decide;
        logic [IDX_W-1:0] idx;
    } rml_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_window;
    } rml_sts_t;

    // atan(2^-i) in 2^-32 turn units
    function automatic logic [TURN_W-1:0] atan_turns(input int unsigned i);
        logic [TURN_W-1:0] a;
        case (i)
            0:  a = 32'd536870912;
            1:  a = 32'd316933406;
            2:  a = 32'd167458907;
            3:  a = 32'd85004756;
            4:  a = 32'd42667331;
            5:  a = 32'd21354465;
            6:  a = 32'd10679838;
            7:  a = 32'd5340245;
            8:  a = 32'd2670163;
            9:  a = 32'd1335087;
            10: a = 32'd667544;
            11: a = 32'd333772;
            12: a = 32'd166886;
            13: a = 32'd83443;
            14: a = 32'd41722;
            15: a = 32'd20861;
            16: a = 32'd10430;
            17: a = 32'd5215;
            18: a = 32'd2608;
            19: a = 32'd1304;
            20: a = 32'd652;
            21: a = 32'd326;
            22: a = 32'd163;
            23: a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- src/rml_ctrl.sv -----
`timescale 1ns / 1ps

module rml_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    input  logic                      in_op,
    output logic                      in_ready,
    input  logic                      out_free,
    output logic                      emit,
    input  logic [rml_pkg::LIM_W-1:0] ring_limit,
    input  rml_pkg::rml_sts_t         sts,
    output rml_pkg::rml_cmd_t         cmd
);
    import rml_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SQX    = 4'd1;
    localparam logic [3:0] ST_SQY    = 4'd2;
    localparam logic [3:0] ST_CORDIC = 4'd3;
    localparam logic [3:0] ST_ROUND  = 4'd4;
    localparam logic [3:0] ST_FETCH  = 4'd5;
    localparam logic [3:0] ST_MUL_HI = 4'd6;
    localparam logic [3:0] ST_MUL_LO = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;
    localparam logic [3:0] ST_EMIT   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             last_ring;

    assign last_ring = (CMP_W'(idx_reg) + CMP_W'(1)) == CMP_W'(ring_limit);

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        cmd        = '0;
        cmd.idx    = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_op == OP_WRITE) begin
                        cmd.write  = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQY;
            end
            ST_SQY: begin
                cmd.sq_y   = 1'b1;
                idx_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                cmd.step = 1'b1;
                if (idx_reg == IDX_W'(ANGLE_BITS - 1)) begin
                    idx_next   = '0;
                    state_next = ST_ROUND;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                if (ring_limit == '0) begin
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                if (sts.in_window || last_ring) begin
                    state_next = ST_EMIT;
                end else begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

// ----- src/rml_dp.sv -----
`timescale 1ns / 1ps

module rml_dp (
    input  logic                              aclk,
    input  rml_pkg::rml_cmd_t                 cmd,
    output rml_pkg::rml_sts_t                 sts,
    input  logic signed [rml_pkg::HIT_W-1:0]  hit_x,
    input  logic signed [rml_pkg::HIT_W-1:0]  hit_y,
    input  logic [rml_pkg::SLOT_W-1:0]        ring_slot,
    input  logic [rml_pkg::RAD_W-1:0]         ring_centre_radius,
    input  logic [rml_pkg::CNT_W-1:0]         ring_module_count,
    input  logic [rml_pkg::HALF_W-1:0]        half_size,
    output logic [rml_pkg::NUM_W-1:0]         res_num,
    output logic                              res_found
);
    import rml_pkg::*;

    logic signed [XW-1:0] x_reg, y_reg;
    logic [TURN_W-1:0]     z_reg;
    logic                  origin_reg;
    logic [MW-1:0]         ax_reg, ay_reg;
    logic [PW-1:0]         sqx_reg, sqy_reg;
    logic [R2_W-1:0]       r2_reg;
    logic [ANGLE_BITS-1:0] turns_reg;
    logic [RAD_W-1:0]      rad_tab_reg [MAX_RINGS];
    logic [CNT_W-1:0]      cnt_tab_reg [MAX_RINGS];
    logic [MW-1:0]         hi_reg, lo_reg;
    logic                  lo_on_reg;
    logic [CNT_W-1:0]      cnt_reg, col_reg;
    logic [PW-1:0]         hi2_reg, lo2_reg;
    logic [NUM_W-1:0]      total_reg, res_num_reg;
    logic                  res_found_reg;

    logic signed [XW-1:0] hx_ext, hy_ext, x_in, y_in, sx, sy;
    logic                  x_neg;
    logic [TURN_W-1:0]     z_round;
    logic [RING_W-1:0]     rsel;
    logic [RAD_W-1:0]      rad_rd;
    logic [CNT_W-1:0]      cnt_rd, col_lim;
    logic [MW-1:0]         mul_a, mul_b;
    logic [PW-1:0]         prod;
    logic                  in_window;

    // Fold the left half-plane onto the right before the vectoring steps
    assign hx_ext = XW'(hit_x);
    assign hy_ext = XW'(hit_y);
    assign x_neg  = hit_x[HIT_W-1];
    assign x_in   = x_neg ? -hx_ext : hx_ext;
    assign y_in   = x_neg ? -hy_ext : hy_ext;

    assign sx      = x_reg >>> cmd.idx;
    assign sy      = y_reg >>> cmd.idx;
    assign z_round = z_reg + ROUND_BIT;

    assign rsel   = cmd.idx[RING_W-1:0];
    assign rad_rd = rad_tab_reg[rsel];
    assign cnt_rd = cnt_tab_reg[rsel];

    // One shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.sq_x) begin
            mul_a = ax_reg;
            mul_b = ax_reg;
        end else if (cmd.sq_y) begin
            mul_a = ay_reg;
            mul_b = ay_reg;
        end else if (cmd.fetch) begin
            mul_a = MW'(turns_reg);
            mul_b = MW'(cnt_rd);
        end else if (cmd.mul_hi) begin
            mul_a = hi_reg;
            mul_b = hi_reg;
        end else if (cmd.mul_lo) begin
            mul_a = lo_reg;
            mul_b = lo_reg;
        end
    end

    assign prod = mul_a * mul_b;

    assign in_window = (r2_reg < R2_W'(hi2_reg)) &&
                       (!lo_on_reg || (r2_reg > R2_W'(lo2_reg)));
    assign col_lim = ((cnt_reg != '0) && (col_reg > cnt_reg - CNT_W'(1))) ?
                     cnt_reg - CNT_W'(1) : col_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.write) begin
            total_reg     <= '0;
            res_num_reg   <= '0;
            res_found_reg <= 1'b0;
        end
        if (cmd.load) begin
            x_reg      <= x_in;
            y_reg      <= y_in;
            z_reg      <= x_neg ? HALF_TURN : '0;
            origin_reg <= (hit_x == '0) && (hit_y == '0);
            ax_reg     <= MW'(x_in);
            ay_reg     <= MW'(hit_y[HIT_W-1] ? -hy_ext : hy_ext);
        end
        if (cmd.write && (int'(ring_slot) < MAX_RINGS)) begin
            rad_tab_reg[RING_W'(ring_slot)] <= ring_centre_radius;
            cnt_tab_reg[RING_W'(ring_slot)] <= ring_module_count;
        end
        if (cmd.sq_x) begin
            sqx_reg <= prod;
        end
        if (cmd.sq_y) begin
            sqy_reg <= prod;
        end
        if (cmd.step) begin
            if (!y_reg[XW-1]) begin
                x_reg <= x_reg + sy;
                y_reg <= y_reg - sx;
                z_reg <= z_reg + atan_turns(int'(cmd.idx));
            end else begin
                x_reg <= x_reg - sy;
                y_reg <= y_reg + sx;
                z_reg <= z_reg - atan_turns(int'(cmd.idx));
            end
        end
        if (cmd.round) begin
            r2_reg    <= R2_W'(sqx_reg) + R2_W'(sqy_reg);
            turns_reg <= origin_reg ? '0 : z_round[TURN_W-1 -: ANGLE_BITS];
        end
        if (cmd.fetch) begin
            hi_reg    <= MW'(rad_rd) + MW'(half_size);
            lo_reg    <= MW'(rad_rd) - MW'(half_size);
            lo_on_reg <= MW'(rad_rd) > MW'(half_size);
            cnt_reg   <= cnt_rd;
            col_reg   <= prod[ANGLE_BITS +: CNT_W];
        end
        if (cmd.mul_hi) begin
            hi2_reg <= prod;
        end
        if (cmd.mul_lo) begin
            lo2_reg <= prod;
        end
        if (cmd.decide) begin
            if (in_window) begin
                res_num_reg   <= total_reg + NUM_W'(col_lim);
                res_found_reg <= 1'b1;
            end else begin
                total_reg <= total_reg + NUM_W'(cnt_reg);
            end
        end
    end

    assign sts.in_window = in_window;
    assign res_num       = res_num_reg;
    assign res_found     = res_found_reg;

endmodule

// ----- src/ring_module_locator_top.sv -----
`timescale 1ns / 1ps

// Locate: SQX, SQY, 16 CORDIC steps on one shared adder set and ROUND, then for each ring examined
//   (0..8) FETCH, MUL_HI, MUL_LO and DECIDE on one multiplier, then EMIT raises m_tvalid.
// Ring table write: the table is written at the input transfer, then EMIT raises m_tvalid.
// Throughput: one item at a time, a new transfer only once the last result is emitted;
//   a result stalled at m_tvalid holds back only the result after it, not the next transfer.
// Reset (aresetn low, synchronous) clears control and both configuration registers.
module ring_module_locator_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // from bit 0: hit_x, hit_y, ring_slot, ring_centre_radius, ring_module_count, zero pad
    input  logic [rml_pkg::S_TDATA_W-1:0]      s_tdata,
    // bit 0: operation
    input  logic                               s_tuser,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0: module_number, zero pad
    output logic [rml_pkg::M_TDATA_W-1:0]      m_tdata,
    // bit 0: found
    output logic                               m_tuser,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rml_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rml_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rml_pkg::*;

    logic [RCNT_W-1:0]    ring_count_reg;
    logic [HALF_W-1:0]    half_size_reg;
    logic [LIM_W-1:0]     ring_limit;

    logic                 m_valid_reg, m_valid_next;
    logic [NUM_W-1:0]     m_num_reg;
    logic                 m_found_reg;

    logic                 out_free;
    logic                 emit;
    rml_cmd_t             cmd;
    rml_sts_t             sts;
    logic [NUM_W-1:0]     res_num;
    logic                 res_found;

    // Configuration: every transfer is taken at once, unknown indexes dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg <= '0;
            half_size_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RING_COUNT: ring_count_reg <= cfg_data[RCNT_W-1:0];
                REG_HALF_SIZE:  half_size_reg  <= cfg_data[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    // Never walk more rings than the table holds
    always_comb begin
        if (int'(ring_count_reg) > MAX_RINGS) begin
            ring_limit = LIM_W'(MAX_RINGS);
        end else begin
            ring_limit = LIM_W'(ring_count_reg);
        end
    end

    // The output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_tready;

    rml_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_op      (s_tuser),
        .in_ready   (s_tready),
        .out_free   (out_free),
        .emit       (emit),
        .ring_limit (ring_limit),
        .sts        (sts),
        .cmd        (cmd)
    );

    rml_dp u_dp (
        .aclk               (aclk),
        .cmd                (cmd),
        .sts                (sts),
        .hit_x              (s_tdata[X_LSB +: HIT_W]),
        .hit_y              (s_tdata[Y_LSB +: HIT_W]),
        .ring_slot          (s_tdata[SLOT_LSB +: SLOT_W]),
        .ring_centre_radius (s_tdata[RAD_LSB +: RAD_W]),
        .ring_module_count  (s_tdata[CNT_LSB +: CNT_W]),
        .half_size          (half_size_reg),
        .res_num            (res_num),
        .res_found          (res_found)
    );

    // Output register: load on emit, hold while stalled, drop after the transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_num_reg   <= res_num;
            m_found_reg <= res_found;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(m_num_reg);
    assign m_tuser  = m_found_reg;

endmodule
